// File: sv/ssf_pkg.sv
// Shared constants, types and the dominance function for the skyline stack filter.
package ssf_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = 11;
    localparam int ID_W        = 31;
    localparam int COORD_W     = 32;
    localparam int IDX_W       = 10;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_PUSHED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ_BAD = 3'd4;

    localparam logic [COUNT_W-1:0] DEPTH_FULL = COUNT_W'(STACK_DEPTH);

    typedef enum logic [0:0] {
        FSM_IDLE,
        FSM_EXEC
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    function automatic logic beats(
        input logic signed [COORD_W-1:0] ax,
        input logic signed [COORD_W-1:0] ay,
        input logic signed [COORD_W-1:0] bx,
        input logic signed [COORD_W-1:0] by
    );
        return (ax <= bx) && (ay >= by) && ((ax < bx) || (ay > by));
    endfunction

endpackage

// File: sv/ssf_item_if.sv
// Input channel of the skyline stack filter: operation and point payload.
interface ssf_item_if;
    import ssf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic [ID_W-1:0]           point_id;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [IDX_W-1:0]          read_index;

    modport source (
        output valid, op, point_id, point_x, point_y, read_index,
        input  ready
    );

    modport sink (
        input  valid, op, point_id, point_x, point_y, read_index,
        output ready
    );
endinterface

// File: sv/ssf_result_if.sv
// Output channel of the skyline stack filter: status, counts and read entry.
interface ssf_result_if;
    import ssf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        entry_count;
    logic [COUNT_W-1:0]        popped_count;
    logic [ID_W-1:0]           entry_id;
    logic signed [COORD_W-1:0] entry_x;
    logic signed [COORD_W-1:0] entry_y;

    modport source (
        output valid, status, entry_count, popped_count, entry_id, entry_x, entry_y,
        input  ready
    );

    modport sink (
        input  valid, status, entry_count, popped_count, entry_id, entry_x, entry_y,
        output ready
    );
endinterface

// File: sv/ssf_stack_mem.sv
// Stack storage: one write port and one registered read port.
module ssf_stack_mem (
    input  logic              clk,
    input  ssf_pkg::mem_req_t req,
    output ssf_pkg::entry_t   rd_data
);
    import ssf_pkg::*;

    entry_t stack_mem [STACK_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            stack_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= stack_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// File: sv/skyline_stack_filter_core.sv
// Skyline stack filter top level: sequencer around the stack memory.
// An insert that pops entries stays in the execute state while each pop reads the next top.
// One transaction is worked on at a time.
// A new transaction is accepted only once the current one has finished.
// The result register frees the input side while a result waits to be taken.
// Reset clears the stack depth and control; memory contents are not cleared.
module skyline_stack_filter_core (
    input  logic   clk,
    input  logic   rst_n,
    ssf_item_if.sink     item,
    ssf_result_if.source result
);
    import ssf_pkg::*;

    state_t                    state_reg, state_next;
    logic [COUNT_W-1:0]        depth_reg, depth_next;
    logic [COUNT_W-1:0]        popped_reg, popped_next;
    logic [OP_W-1:0]           op_reg;
    logic [ID_W-1:0]           id_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic [IDX_W-1:0]          idx_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        popped_out_reg;
    entry_t                    entry_reg;

    mem_req_t                  mem_req;
    entry_t                    top;

    logic                      accept;
    logic                      out_free;
    logic                      top_ok;
    logic                      new_beats_top;
    logic                      top_beats_new;
    logic                      pop;
    logic                      finish;
    logic [STATUS_W-1:0]       res_status;
    logic [COUNT_W-1:0]        res_count;
    entry_t                    res_entry;

    ssf_stack_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (top)
    );

    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign item.ready = (state_reg == FSM_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (finish)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        top_ok        = (depth_reg != '0);
        new_beats_top = top_ok && beats(x_reg, y_reg, top.x, top.y);
        top_beats_new = top_ok && beats(top.x, top.y, x_reg, y_reg);
        pop           = (state_reg == FSM_EXEC) && (op_reg == OP_INSERT) && new_beats_top;
        finish        = (state_reg == FSM_EXEC) && !pop && out_free;

        mem_req.rd_en   = accept || pop;
        if (accept)
        begin
            mem_req.rd_addr = (item.op == OP_READ) ? ADDR_W'(item.read_index)
                                                   : ADDR_W'(depth_reg - 1'b1);
        end
        else
        begin
            mem_req.rd_addr = ADDR_W'(depth_reg - 2'd2);
        end
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = depth_reg[ADDR_W-1:0];
        mem_req.wr_data = '{id: id_reg, x: x_reg, y: y_reg};

        res_status  = ST_READ_BAD;
        res_count   = depth_reg;
        res_entry   = '0;
        depth_next  = depth_reg;
        popped_next = popped_reg;

        if (accept)
        begin
            popped_next = '0;
        end
        else if (pop)
        begin
            depth_next  = depth_reg - 1'b1;
            popped_next = popped_reg + 1'b1;
        end

        case (op_reg)
            OP_INSERT:
            begin
                if (top_beats_new)
                begin
                    res_status = ST_REJECTED;
                end
                else if (depth_reg == DEPTH_FULL)
                begin
                    res_status = ST_OVERFLOW;
                end
                else
                begin
                    res_status    = ST_PUSHED;
                    res_count     = depth_reg + 1'b1;
                    mem_req.wr_en = finish;
                    if (finish)
                    begin
                        depth_next = depth_reg + 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                if (COUNT_W'(idx_reg) < depth_reg)
                begin
                    res_status = ST_READ_OK;
                    res_entry  = top;
                end
            end
            OP_CLEAR:
            begin
                res_count = '0;
                if (finish)
                begin
                    depth_next = '0;
                end
            end
            default:
            begin
                res_status = ST_READ_BAD;
            end
        endcase

        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            depth_reg     <= '0;
            popped_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            popped_reg    <= popped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= item.op;
            id_reg  <= item.point_id;
            x_reg   <= item.point_x;
            y_reg   <= item.point_y;
            idx_reg <= item.read_index;
        end
        if (finish)
        begin
            status_reg     <= res_status;
            count_reg      <= res_count;
            popped_out_reg <= (op_reg == OP_INSERT) ? popped_reg : '0;
            entry_reg      <= res_entry;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = status_reg;
    assign result.entry_count  = count_reg;
    assign result.popped_count = popped_out_reg;
    assign result.entry_id     = entry_reg.id;
    assign result.entry_x      = entry_reg.x;
    assign result.entry_y      = entry_reg.y;
endmodule

// File: sv/ssf_checker.sv
// Port-level assertions for the skyline stack filter, bound to the top level.
module ssf_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               result_valid,
    input logic                               result_ready,
    input logic [ssf_pkg::STATUS_W-1:0]       status,
    input logic [ssf_pkg::COUNT_W-1:0]        entry_count,
    input logic [ssf_pkg::COUNT_W-1:0]        popped_count,
    input logic [ssf_pkg::ID_W-1:0]           entry_id,
    input logic signed [ssf_pkg::COORD_W-1:0] entry_x,
    input logic signed [ssf_pkg::COORD_W-1:0] entry_y
);
    import ssf_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(status)
            && $stable(entry_count))
        else $error("result dropped or changed while stalled");

    a_insert_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_PUSHED || status == ST_REJECTED
            || status == ST_OVERFLOW)
        |-> entry_id == '0 && entry_x == '0 && entry_y == '0)
        else $error("insert transaction carries entry data");

    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_READ_OK |-> popped_count == '0 && entry_count != '0)
        else $error("read transaction with bad counts");

    a_pushed_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_PUSHED |-> entry_count != '0
            && entry_count <= DEPTH_FULL)
        else $error("push reports impossible depth");
endmodule

bind skyline_stack_filter_core ssf_checker u_ssf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (result.status),
    .entry_count  (result.entry_count),
    .popped_count (result.popped_count),
    .entry_id     (result.entry_id),
    .entry_x      (result.entry_x),
    .entry_y      (result.entry_y)
);
